>>> rtl/rrsd_pkg.sv
package rrsd_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int GROUP_DEPTH  = 4;

    localparam logic [31:0] RX_MAGIC = 32'h744E6350;

    // configuration register indexes
    localparam logic CFG_CONNECTION = 1'b0;
    localparam logic CFG_REPLY_TYPE = 1'b1;

    // input opcodes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;
    localparam logic [1:0] KIND_REFUSED = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_SEQ_BAD   = 3'd2;
    localparam logic [2:0] ST_CONN_BAD  = 3'd3;
    localparam logic [2:0] ST_MAGIC_BAD = 3'd4;
    localparam logic [2:0] ST_LEN_BAD   = 3'd5;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP,
        PH_TOOLONG
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] buffer_offset;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] reply_length;
    } t_result;

    // results caused by one input item, in order; cnt is 1 or 2 when written
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_group;

endpackage

>>> rtl/rrsd_front.sv
module rrsd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_opcode,
    input  logic [7:0]             i_rx_byte,
    input  logic [7:0]             i_request_sequence,
    input  logic [15:0]            i_max_reply_len,
    input  logic                   i_alloc_slot,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_wr,
    output rrsd_pkg::t_group       o_group
);

    localparam logic [3:0] LastHdr = 4'(rrsd_pkg::HEADER_BYTES - 1);

    rrsd_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_hcnt, n_hcnt;
    logic [31:0] r_magic, n_magic;
    logic [27:0] r_hlen, n_hlen;
    logic [15:0] r_htype, n_htype;
    logic [27:0] r_rem, n_rem;
    logic [15:0] r_woff, n_woff;
    logic        r_pend, n_pend;
    logic [7:0]  r_pseq, n_pseq;
    logic [15:0] r_pmax, n_pmax;
    logic        r_palloc, n_palloc;
    logic [7:0]  r_sseq, n_sseq;
    logic [15:0] r_sconn, n_sconn;
    logic        r_dead, n_dead;
    logic [15:0] r_conn_cfg;
    logic [15:0] r_type_cfg;

    logic [16:0] max_plus;
    logic [27:0] rem_dec;
    logic [27:0] hdr_rem;
    logic        hdr_done;

    function automatic rrsd_pkg::t_result f_finish(
        input logic        alloc,
        input logic [27:0] len,
        input logic [7:0]  seq_seen,
        input logic [7:0]  seq_pend,
        input logic [15:0] conn_seen,
        input logic [15:0] conn_cfg
    );
        rrsd_pkg::t_result res;
        logic [2:0]        st;
        logic [27:0]       rlen;
        st   = rrsd_pkg::ST_OK;
        rlen = len - 28'd8;
        if (!alloc) begin
            if (len < 28'd11 || seq_seen != seq_pend) begin
                st = rrsd_pkg::ST_SEQ_BAD;
            end else if (len < 28'd14 || conn_seen != conn_cfg) begin
                st = rrsd_pkg::ST_CONN_BAD;
            end
        end
        res = '0;
        if (st == rrsd_pkg::ST_OK) begin
            res.kind         = rrsd_pkg::KIND_DONE;
            res.reply_length = rlen[15:0];
        end else begin
            res.kind   = rrsd_pkg::KIND_ABORT;
            res.status = st;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= rrsd_pkg::PH_HEADER;
            r_hcnt     <= '0;
            r_magic    <= '0;
            r_hlen     <= '0;
            r_htype    <= '0;
            r_rem      <= '0;
            r_woff     <= 16'd2;
            r_pend     <= 1'b0;
            r_pseq     <= '0;
            r_pmax     <= '0;
            r_palloc   <= 1'b0;
            r_sseq     <= '0;
            r_sconn    <= '0;
            r_dead     <= 1'b0;
            r_conn_cfg <= 16'hFFFF;
            r_type_cfg <= 16'h3333;
        end else begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_magic  <= n_magic;
            r_hlen   <= n_hlen;
            r_htype  <= n_htype;
            r_rem    <= n_rem;
            r_woff   <= n_woff;
            r_pend   <= n_pend;
            r_pseq   <= n_pseq;
            r_pmax   <= n_pmax;
            r_palloc <= n_palloc;
            r_sseq   <= n_sseq;
            r_sconn  <= n_sconn;
            r_dead   <= n_dead;
            if (i_cfg_we) begin
                if (i_cfg_idx == rrsd_pkg::CFG_CONNECTION) begin
                    r_conn_cfg <= i_cfg_data;
                end else begin
                    r_type_cfg <= i_cfg_data;
                end
            end
        end
    end

    assign max_plus = {1'b0, r_pmax} + 17'd8;
    assign rem_dec  = r_rem - 28'd1;
    assign hdr_rem  = n_hlen - 28'd10;
    assign hdr_done = (r_hcnt == LastHdr);

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_magic  = r_magic;
        n_hlen   = r_hlen;
        n_htype  = r_htype;
        n_rem    = r_rem;
        n_woff   = r_woff;
        n_pend   = r_pend;
        n_pseq   = r_pseq;
        n_pmax   = r_pmax;
        n_palloc = r_palloc;
        n_sseq   = r_sseq;
        n_sconn  = r_sconn;
        n_dead   = r_dead;
        o_group  = '0;

        if (i_valid) begin
            if (i_opcode == rrsd_pkg::OP_START) begin
                if (r_dead || r_pend) begin
                    o_group.cnt     = 2'd1;
                    o_group.r0.kind = rrsd_pkg::KIND_REFUSED;
                end else begin
                    n_pend   = 1'b1;
                    n_pseq   = i_request_sequence;
                    n_pmax   = i_max_reply_len;
                    n_palloc = i_alloc_slot;
                end
            end else if (!r_dead) begin
                unique case (r_phase)
                    rrsd_pkg::PH_HEADER: begin
                        if (r_hcnt < 4'd4) begin
                            n_magic = {r_magic[23:0], i_rx_byte};
                        end else if (r_hcnt < 4'd8) begin
                            n_hlen = {r_hlen[19:0], i_rx_byte};
                        end else begin
                            n_htype = {r_htype[7:0], i_rx_byte};
                        end
                        n_hcnt = r_hcnt + 4'd1;
                        if (hdr_done) begin
                            n_hcnt = '0;
                            if (n_magic != rrsd_pkg::RX_MAGIC || n_hlen < 28'd10) begin
                                o_group.cnt       = 2'd1;
                                o_group.r0.kind   = rrsd_pkg::KIND_ABORT;
                                o_group.r0.status = (n_magic != rrsd_pkg::RX_MAGIC) ?
                                    rrsd_pkg::ST_MAGIC_BAD : rrsd_pkg::ST_LEN_BAD;
                                n_dead = 1'b1;
                                n_pend = 1'b0;
                            end else begin
                                n_rem = hdr_rem;
                                if (n_htype != r_type_cfg || !r_pend) begin
                                    n_phase = (hdr_rem == '0) ? rrsd_pkg::PH_HEADER
                                                              : rrsd_pkg::PH_SKIP;
                                end else if (n_hlen > {11'd0, max_plus}) begin
                                    if (hdr_rem == '0) begin
                                        n_pend            = 1'b0;
                                        o_group.cnt       = 2'd1;
                                        o_group.r0.kind   = rrsd_pkg::KIND_DONE;
                                        o_group.r0.status = rrsd_pkg::ST_TOO_LONG;
                                    end else begin
                                        n_phase = rrsd_pkg::PH_TOOLONG;
                                    end
                                end else begin
                                    n_woff = 16'd2;
                                    if (hdr_rem == '0) begin
                                        // empty reply: check at once
                                        o_group.cnt = 2'd1;
                                        o_group.r0  = f_finish(r_palloc, n_hlen, r_sseq,
                                                               r_pseq, r_sconn, r_conn_cfg);
                                        n_pend = 1'b0;
                                        if (o_group.r0.kind == rrsd_pkg::KIND_ABORT) begin
                                            n_dead = 1'b1;
                                        end
                                    end else begin
                                        n_phase = rrsd_pkg::PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    rrsd_pkg::PH_PAYLOAD: begin
                        o_group.cnt              = 2'd1;
                        o_group.r0.kind          = rrsd_pkg::KIND_PAYLOAD;
                        o_group.r0.buffer_offset = r_woff;
                        o_group.r0.payload_byte  = i_rx_byte;
                        if (r_woff == 16'd2) begin
                            n_sseq = i_rx_byte;
                        end else if (r_woff == 16'd3) begin
                            n_sconn = {r_sconn[15:8], i_rx_byte};
                        end else if (r_woff == 16'd5) begin
                            n_sconn = {i_rx_byte, r_sconn[7:0]};
                        end
                        n_woff = r_woff + 16'd1;
                        n_rem  = rem_dec;
                        if (rem_dec == '0) begin
                            o_group.cnt = 2'd2;
                            o_group.r1  = f_finish(r_palloc, r_hlen, n_sseq, r_pseq,
                                                   n_sconn, r_conn_cfg);
                            n_pend  = 1'b0;
                            n_phase = rrsd_pkg::PH_HEADER;
                            n_woff  = 16'd2;
                            if (o_group.r1.kind == rrsd_pkg::KIND_ABORT) begin
                                n_dead = 1'b1;
                            end
                        end
                    end
                    rrsd_pkg::PH_TOOLONG: begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_pend            = 1'b0;
                            n_phase           = rrsd_pkg::PH_HEADER;
                            o_group.cnt       = 2'd1;
                            o_group.r0.kind   = rrsd_pkg::KIND_DONE;
                            o_group.r0.status = rrsd_pkg::ST_TOO_LONG;
                        end
                    end
                    rrsd_pkg::PH_SKIP: begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = rrsd_pkg::PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = rrsd_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    assign o_wr = (o_group.cnt != 2'd0);

endmodule

>>> rtl/rrsd_fifo.sv
module rrsd_fifo #(
    parameter int DEPTH = rrsd_pkg::GROUP_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  rrsd_pkg::t_group   i_wdata,
    input  logic               i_rd,
    output rrsd_pkg::t_group   o_rdata,
    output logic               o_nonempty,
    output logic               o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rrsd_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_wr, do_rd;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_rdata    = r_mem[r_rptr];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

>>> rtl/rrsd_back.sv
module rrsd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrsd_pkg::t_group   i_group,
    input  logic               i_group_valid,
    output logic               o_group_rd,
    output logic               empty,
    input  logic               pop,
    output rrsd_pkg::t_result  o_result,
    output logic               o_last
);

    rrsd_pkg::t_group r_cur;
    logic             r_valid;
    logic             r_idx;
    logic             take, consume, load;

    assign o_last   = (r_cur.cnt == 2'd1) || r_idx;
    assign o_result = r_idx ? r_cur.r1 : r_cur.r0;
    assign empty    = !r_valid;

    assign take       = r_valid && pop;
    assign consume    = take && o_last;
    assign load       = (!r_valid || consume) && i_group_valid;
    assign o_group_rd = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= 1'b0;
            end else if (consume) begin
                r_valid <= 1'b0;
                r_idx   <= 1'b0;
            end else if (take) begin
                // advance to the second beat of this group
                r_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_group;
        end
    end

endmodule

>>> rtl/rpc_reply_stream_deframer.sv
// Reply deframer for a request/reply protocol carried over a TCP byte stream.
// Input channel (push/full): each beat is either one received stream byte
// (opcode 0) or a start command (opcode 1) that arms the single outstanding
// request with its sequence, reply buffer size and slot-allocation flag.
// Result channel (empty/pop): each beat is a payload byte with its buffer
// offset, a request completion, a connection abort or a refused start;
// o_last marks the final beat caused by one input beat (at most two).
// Configuration: i_cfg_we writes connection number (index 0) or reply type
// code (index 1); write only while the block is idle.
// Throughput: one input beat per cycle while full is low; the parser never
// stalls a beat, and the result side drains one beat per cycle while pop is
// high, so an input that ends a reply yields two result beats. A four-entry queue of
// result groups sits between parser and output register; full rises when it
// fills, e.g. while the receiver holds pop low.
// Reset clears the parser to header phase, drops any pending request,
// empties the queue and restores both configuration registers.
module rpc_reply_stream_deframer #(
    parameter int GROUP_DEPTH = rrsd_pkg::GROUP_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_request_sequence,
    input  logic [15:0] i_max_reply_len,
    input  logic        i_alloc_slot,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [15:0] o_buffer_offset,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [15:0] o_reply_length,
    output logic        o_last
);

    logic              accept;
    logic              grp_wr;
    rrsd_pkg::t_group  grp_wdata;
    rrsd_pkg::t_group  grp_rdata;
    logic              grp_nonempty;
    logic              grp_rd;
    rrsd_pkg::t_result res;

    assign accept = push && !full;

    rrsd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (accept),
        .i_opcode           (i_opcode),
        .i_rx_byte          (i_rx_byte),
        .i_request_sequence (i_request_sequence),
        .i_max_reply_len    (i_max_reply_len),
        .i_alloc_slot       (i_alloc_slot),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_wr               (grp_wr),
        .o_group            (grp_wdata)
    );

    rrsd_fifo #(
        .DEPTH (GROUP_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (grp_wr),
        .i_wdata    (grp_wdata),
        .i_rd       (grp_rd),
        .o_rdata    (grp_rdata),
        .o_nonempty (grp_nonempty),
        .o_full     (full)
    );

    rrsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (grp_rdata),
        .i_group_valid (grp_nonempty),
        .o_group_rd    (grp_rd),
        .empty         (empty),
        .pop           (pop),
        .o_result      (res),
        .o_last        (o_last)
    );

    assign o_kind          = res.kind;
    assign o_buffer_offset = res.buffer_offset;
    assign o_payload_byte  = res.payload_byte;
    assign o_status        = res.status;
    assign o_reply_length  = res.reply_length;

endmodule

>>> dv/tb_rpc_reply_stream_deframer.sv
`timescale 1ns / 1ps

module tb_rpc_reply_stream_deframer;
    import rrsd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BEATS = 60;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  rx_byte;
        logic [7:0]  req_seq;
        logic [15:0] max_len;
        logic        alloc;
    } rx_item_t;

    typedef struct packed {
        logic    tail;
        t_result res;
    } parsed_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic [7:0]  i_request_sequence = 8'd0;
    logic [15:0] i_max_reply_len = 16'd0;
    logic        i_alloc_slot = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_CONNECTION;
    logic [15:0] i_cfg_data = 16'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_buffer_offset;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status;
    logic [15:0] o_reply_length;
    logic        o_last;

    rpc_reply_stream_deframer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_opcode           (i_opcode),
        .i_rx_byte          (i_rx_byte),
        .i_request_sequence (i_request_sequence),
        .i_max_reply_len    (i_max_reply_len),
        .i_alloc_slot       (i_alloc_slot),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .empty              (empty),
        .pop                (pop),
        .o_kind             (o_kind),
        .o_buffer_offset    (o_buffer_offset),
        .o_payload_byte     (o_payload_byte),
        .o_status           (o_status),
        .o_reply_length     (o_reply_length),
        .o_last             (o_last)
    );

    always #2 i_clk = ~i_clk;

    rx_item_t stream_q[$];
    parsed_t  parsed_q[$];
    rx_item_t cur_item;
    parsed_t  want;
    int       send_gap, pop_gap, send_mode, pop_mode;
    int       cyc, n_errors, n_beats, n_results;
    int       kind_seen[4];
    string    end_case = "none";

    // deframer state as the predictor sees it
    logic [15:0] cfg_conn, cfg_type;
    t_phase      ph;
    int          hdr_cnt;
    logic [31:0] hdr_magic, hdr_len;
    logic [15:0] hdr_type;
    logic [27:0] remain;
    logic [15:0] wr_off;
    logic        pend, pend_alloc, dead;
    logic [7:0]  pend_seq, seen_seq;
    logic [15:0] pend_max, seen_conn;

    // stream generator's view of the outstanding request
    logic        g_pend, g_alloc;
    logic [7:0]  g_seq;
    logic [15:0] g_max;

    task automatic report(string msg);
        n_errors++;
        if (n_errors <= 30)
            $display("ERROR cycle %0d: %s", cyc, msg);
    endtask

    task automatic check_field(string what, int unsigned got, int unsigned exp_val);
        if (got != exp_val)
            report($sformatf("%s got %0d, want %0d", what, got, exp_val));
    endtask

    function automatic int idle_len(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 25) ? $urandom_range(1, 2) : 0;
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_result result_of(logic [1:0] k, logic [15:0] off, logic [7:0] b,
                                          logic [2:0] st, logic [15:0] rlen);
        t_result r;
        r.kind          = k;
        r.buffer_offset = off;
        r.payload_byte  = b;
        r.status        = st;
        r.reply_length  = rlen;
        return r;
    endfunction

    function automatic void rewind_header();
        ph      = PH_HEADER;
        hdr_cnt = 0;
        wr_off  = 16'd2;
    endfunction

    function automatic void reset_deframer();
        cfg_conn   = 16'hFFFF;
        cfg_type   = 16'd13107;
        hdr_magic  = '0;
        hdr_len    = '0;
        hdr_type   = '0;
        remain     = '0;
        pend       = 1'b0;
        pend_seq   = '0;
        pend_max   = '0;
        pend_alloc = 1'b0;
        seen_seq   = '0;
        seen_conn  = '0;
        dead       = 1'b0;
        rewind_header();
    endfunction

    // end of an accepted reply: check sequence and connection, close the request
    function automatic t_result close_reply();
        logic [27:0] plen;
        logic [2:0]  st;
        plen = hdr_len[27:0] - 28'd10;
        st   = ST_OK;
        if (!pend_alloc) begin
            if (plen < 1 || seen_seq != pend_seq)
                st = ST_SEQ_BAD;
            else if (plen < 4 || seen_conn != cfg_conn)
                st = ST_CONN_BAD;
        end
        pend = 1'b0;
        rewind_header();
        if (st == ST_OK)
            return result_of(KIND_DONE, 16'd0, 8'd0, ST_OK, 16'(hdr_len[27:0] - 28'd8));
        dead = 1'b1;
        return result_of(KIND_ABORT, 16'd0, 8'd0, st, 16'd0);
    endfunction

    function automatic void parse_beat(rx_item_t it);
        t_result     res[2];
        int          n;
        logic [27:0] flen;
        logic [7:0]  b;
        n = 0;
        b = it.rx_byte;
        if (it.opcode == OP_START) begin
            if (dead || pend) begin
                res[0] = result_of(KIND_REFUSED, 16'd0, 8'd0, ST_OK, 16'd0);
                n = 1;
            end else begin
                pend       = 1'b1;
                pend_seq   = it.req_seq;
                pend_max   = it.max_len;
                pend_alloc = it.alloc;
            end
        end else if (!dead) begin
            case (ph)
                PH_HEADER: begin
                    if (hdr_cnt < 4)
                        hdr_magic = {hdr_magic[23:0], b};
                    else if (hdr_cnt < 8)
                        hdr_len = {hdr_len[23:0], b};
                    else
                        hdr_type = {hdr_type[7:0], b};
                    hdr_cnt++;
                    if (hdr_cnt == HEADER_BYTES) begin
                        flen    = hdr_len[27:0];
                        hdr_cnt = 0;
                        if (hdr_magic != RX_MAGIC || flen < 10) begin
                            res[0] = result_of(KIND_ABORT, 16'd0, 8'd0,
                                               (hdr_magic != RX_MAGIC) ? ST_MAGIC_BAD : ST_LEN_BAD,
                                               16'd0);
                            dead = 1'b1;
                            pend = 1'b0;
                            n    = 1;
                        end else begin
                            remain = flen - 28'd10;
                            if (hdr_type != cfg_type || !pend) begin
                                ph = PH_SKIP;
                                if (remain == 0)
                                    rewind_header();
                            end else if ({4'd0, flen} > {16'd0, pend_max} + 32'd8) begin
                                ph = PH_TOOLONG;
                                if (remain == 0) begin
                                    pend = 1'b0;
                                    rewind_header();
                                    res[0] = result_of(KIND_DONE, 16'd0, 8'd0, ST_TOO_LONG, 16'd0);
                                    n = 1;
                                end
                            end else begin
                                ph     = PH_PAYLOAD;
                                wr_off = 16'd2;
                                if (remain == 0) begin
                                    res[0] = close_reply();
                                    n = 1;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res[0] = result_of(KIND_PAYLOAD, wr_off, b, ST_OK, 16'd0);
                    n = 1;
                    if (wr_off == 16'd2)
                        seen_seq = b;
                    else if (wr_off == 16'd3)
                        seen_conn[7:0] = b;
                    else if (wr_off == 16'd5)
                        seen_conn[15:8] = b;
                    wr_off = wr_off + 16'd1;
                    remain = remain - 28'd1;
                    if (remain == 0) begin
                        res[1] = close_reply();
                        n = 2;
                    end
                end
                PH_TOOLONG: begin
                    remain = remain - 28'd1;
                    if (remain == 0) begin
                        pend = 1'b0;
                        rewind_header();
                        res[0] = result_of(KIND_DONE, 16'd0, 8'd0, ST_TOO_LONG, 16'd0);
                        n = 1;
                    end
                end
                default: begin
                    remain = remain - 28'd1;
                    if (remain == 0)
                        rewind_header();
                end
            endcase
        end
        for (int i = 0; i < n; i++)
            parsed_q.push_back(parsed_t'{tail: (i == n - 1), res: res[i]});
    endfunction

    // ---------------- stream generation ----------------

    task automatic put_item(logic op, logic [7:0] b, logic [7:0] sq, logic [15:0] ml, logic al);
        rx_item_t it;
        it.opcode  = op;
        it.rx_byte = b;
        it.req_seq = sq;
        it.max_len = ml;
        it.alloc   = al;
        stream_q.push_back(it);
    endtask

    task automatic put_byte(logic [7:0] b);
        put_item(OP_BYTE, b, 8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic put_start(logic [7:0] sq, logic [15:0] ml, logic al);
        put_item(OP_START, 8'($urandom), sq, ml, al);
        if (!g_pend) begin
            g_pend  = 1'b1;
            g_seq   = sq;
            g_max   = ml;
            g_alloc = al;
        end
    endtask

    task automatic put_header(logic [31:0] magic, logic [27:0] len, logic [15:0] typ);
        logic [31:0] lw;
        // upper nibble of the length word is ignored by the block
        lw = {4'($urandom), len};
        for (int i = 0; i < 4; i++)
            put_byte(magic[31 - 8*i -: 8]);
        for (int i = 0; i < 4; i++)
            put_byte(lw[31 - 8*i -: 8]);
        put_byte(typ[15:8]);
        put_byte(typ[7:0]);
    endtask

    task automatic put_frame(int plen, logic [15:0] typ, logic [7:0] sq, logic [15:0] conn);
        logic [7:0] b;
        put_header(RX_MAGIC, 28'(plen + 10), typ);
        for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            if (i == 0)
                b = sq;
            else if (i == 1)
                b = conn[7:0];
            else if (i == 3)
                b = conn[15:8];
            put_byte(b);
        end
        // a reply-typed frame closes any outstanding request
        if (typ == cfg_type)
            g_pend = 1'b0;
    endtask

    function automatic logic [15:0] pick_max();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(6, 40));
        if (r < 85)
            return 16'($urandom_range(0, 8));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic answer_request(bit too_long);
        int hi, lo;
        hi = int'(g_max) - 2;
        if (hi > 40)
            hi = 40;
        lo = g_alloc ? 0 : 4;
        if ((too_long && g_max <= 30) || hi < lo) begin
            lo = (g_max >= 2) ? int'(g_max) - 1 : 0;
            put_frame($urandom_range(lo, lo + 6), cfg_type, 8'($urandom), 16'($urandom));
        end else begin
            put_frame($urandom_range(lo, hi), cfg_type, g_seq, cfg_conn);
        end
    endtask

    task automatic random_episode();
        int          r;
        logic [15:0] typ;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            if (!g_pend)
                put_start(8'($urandom), pick_max(), ($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 4) == 0)
                put_frame($urandom_range(0, 12), cfg_type ^ 16'($urandom_range(1, 65535)),
                          8'($urandom), 16'($urandom));
            if ($urandom_range(0, 5) == 0)
                put_start(8'($urandom), 16'($urandom), 1'($urandom));
            answer_request(1'b0);
        end else if (r < 65) begin
            if (!g_pend)
                put_start(8'($urandom), 16'($urandom_range(0, 20)), 1'($urandom));
            answer_request(1'b1);
        end else if (r < 85) begin
            if (g_pend || $urandom_range(0, 1) == 0)
                typ = cfg_type ^ 16'($urandom_range(1, 65535));
            else
                typ = cfg_type;
            put_frame($urandom_range(0, 24), typ, 8'($urandom), 16'($urandom));
        end else begin
            put_start(8'($urandom), pick_max(), 1'($urandom));
        end
    endtask

    // kill the connection one way or another, then show it stays dead
    task automatic end_connection();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick >= 2) begin
            if (g_pend)
                answer_request(1'b0);
            put_start(8'($urandom), 16'd40, 1'b0);
        end
        case (pick)
            0: begin
                end_case = "bad magic";
                put_header(RX_MAGIC ^ (32'd1 << $urandom_range(0, 31)),
                           28'($urandom_range(10, 30)), cfg_type);
            end
            1: begin
                end_case = "bad length";
                put_header(RX_MAGIC, 28'($urandom_range(0, 9)), 16'($urandom));
            end
            2: begin
                end_case = "sequence mismatch";
                put_frame($urandom_range(4, 20), cfg_type,
                          g_seq ^ 8'($urandom_range(1, 255)), cfg_conn);
            end
            3: begin
                end_case = "connection mismatch";
                put_frame($urandom_range(6, 20), cfg_type, g_seq,
                          cfg_conn ^ 16'($urandom_range(1, 65535)));
            end
            4: begin
                end_case = "empty checked reply";
                put_frame(0, cfg_type, g_seq, cfg_conn);
            end
            default: begin
                end_case = "short checked reply";
                put_frame($urandom_range(1, 3), cfg_type, g_seq, cfg_conn);
            end
        endcase
        repeat (5) put_byte(8'($urandom));
        put_start(8'($urandom), 16'($urandom), 1'($urandom));
        repeat (3) put_byte(8'($urandom));
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CONNECTION)
            cfg_conn = val;
        else
            cfg_type = val;
    endtask

    // look just after the edge so the driver and monitor updates have landed
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (stream_q.size() != 0 || push || parsed_q.size() != 0 || !empty);
        repeat (8) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                n_beats++;
                parse_beat(cur_item);
            end
            if (push && full) begin
                // hold the beat until taken
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (stream_q.size() != 0) begin
                cur_item = stream_q.pop_front();
                i_opcode           <= cur_item.opcode;
                i_rx_byte          <= cur_item.rx_byte;
                i_request_sequence <= cur_item.req_seq;
                i_max_reply_len    <= cur_item.max_len;
                i_alloc_slot       <= cur_item.alloc;
                push               <= 1'b1;
                send_gap = idle_len(send_mode);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                kind_seen[o_kind]++;
                if (parsed_q.size() == 0) begin
                    report($sformatf("unexpected result beat, kind %0d", o_kind));
                end else begin
                    want = parsed_q.pop_front();
                    check_field("kind", o_kind, want.res.kind);
                    check_field("buffer_offset", o_buffer_offset, want.res.buffer_offset);
                    check_field("payload_byte", o_payload_byte, want.res.payload_byte);
                    check_field("status", o_status, want.res.status);
                    check_field("reply_length", o_reply_length, want.res.reply_length);
                    check_field("last", o_last, want.tail);
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                pop_gap = idle_len(pop_mode);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cyc, parsed_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        reset_deframer();
        g_pend    = 1'b0;
        send_mode = 0;
        pop_mode  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset register values, no idling
        put_start(8'hFF, 16'hFFFF, 1'b0);
        put_start(8'h00, 16'h0000, 1'b1);       // refused, request already armed
        put_frame(4, cfg_type, g_seq, cfg_conn); // shortest checked reply
        put_start(8'h00, 16'h0000, 1'b1);
        put_frame(0, cfg_type, 8'd0, 16'd0);     // too long with nothing to skip
        put_start(8'h5A, 16'd2, 1'b1);
        put_frame(0, cfg_type, 8'd0, 16'd0);     // empty reply accepted at header end
        drain();

        for (int p = 1; p <= 5; p++) begin
            case (p)
                1: begin
                    write_reg(CFG_CONNECTION, 16'h0000);
                    write_reg(CFG_REPLY_TYPE, 16'h0000);
                end
                2: begin
                    write_reg(CFG_CONNECTION, 16'hFFFF);
                    write_reg(CFG_REPLY_TYPE, 16'hFFFF);
                end
                default: begin
                    write_reg(CFG_CONNECTION, 16'($urandom));
                    write_reg(CFG_REPLY_TYPE, 16'($urandom));
                end
            endcase
            send_mode = (p == 1) ? 0 : $urandom_range(1, 2);
            pop_mode  = (p == 1) ? 0 : $urandom_range(1, 2);
            while (stream_q.size() < PHASE_BEATS)
                random_episode();
            if (p == 5)
                end_connection();
            drain();
        end

        $display("Run covered %0d input beats and %0d result beats over six register settings",
                 n_beats, n_results);
        $display("Payload %0d, done %0d, abort %0d, refused %0d; connection closed by %s",
                 kind_seen[KIND_PAYLOAD], kind_seen[KIND_DONE], kind_seen[KIND_ABORT],
                 kind_seen[KIND_REFUSED], end_case);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
